/* rtl/core/vcsp_pkg.sv */
// ============================================================================
// VGM command stream parser package
// Record layout, record kinds and command opcodes shared by the parser core,
// its output queue and the top level.
// ============================================================================
package vcsp_pkg;

    // Kind of a parsed record.
    typedef enum logic [2:0] {
        KIND_END         = 3'd0,
        KIND_WAIT        = 3'd1,
        KIND_REG_WRITE   = 3'd2,
        KIND_BLOCK_HDR   = 3'd3,
        KIND_BLOCK_BYTE  = 3'd4,
        KIND_PCM_SEEK    = 3'd5,
        KIND_UNKNOWN     = 3'd6,
        KIND_NO_MARKER   = 3'd7
    } kind_t;

    // Command opcodes.
    localparam logic [7:0] OP_END        = 8'h66;
    localparam logic [7:0] OP_WAIT       = 8'h61;
    localparam logic [7:0] OP_WAIT_NTSC  = 8'h62;
    localparam logic [7:0] OP_WAIT_PAL   = 8'h63;
    localparam logic [7:0] OP_BLOCK      = 8'h67;
    localparam logic [7:0] OP_SEEK       = 8'hE0;
    localparam logic [7:0] OP_WRITE_DATA = 8'h50;
    localparam logic [7:0] OP_WRITE_LO   = 8'h51;
    localparam logic [7:0] OP_WRITE_HI   = 8'h5B;
    localparam logic [7:0] OP_WRITE_A0   = 8'hA0;
    localparam logic [7:0] OP_PORT1_A    = 8'h53;
    localparam logic [7:0] OP_PORT1_B    = 8'h57;
    localparam logic [7:0] OP_PORT1_C    = 8'h59;
    localparam logic [3:0] OP_SHORT_WAIT = 4'h7;
    localparam logic [7:0] BLOCK_MARKER  = 8'h66;

    // Fixed wait lengths in samples.
    localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
    localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;

    // One output record.
    typedef struct packed {
        kind_t        record_kind;
        logic [7:0]   opcode;
        logic [15:0]  wait_samples;
        logic [7:0]   chip_register;
        logic [7:0]   chip_value;
        logic         chip_port;
        logic [7:0]   block_kind;
        logic [31:0]  block_length;
        logic [31:0]  sample_offset;
        logic [7:0]   payload_byte;
        logic         payload_last;
    } record_t;

    // Operand bytes that follow an opcode before its record is complete.
    function automatic logic [2:0] operands_needed(input logic [7:0] op);
        logic [2:0] n;
        n = 3'd0;
        if (op == OP_WAIT) n = 3'd2;
        else if (op == OP_SEEK) n = 3'd4;
        else if (op == OP_WRITE_DATA) n = 3'd1;
        else if ((op >= OP_WRITE_LO && op <= OP_WRITE_HI) || op == OP_WRITE_A0) n = 3'd2;
        return n;
    endfunction

endpackage

/* rtl/core/vcsp_parser.sv */
// ============================================================================
// VGM command stream parser core
// Holds the parse state and turns each accepted word into at most one record.
// ============================================================================
module vcsp_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         stream_byte,
    output logic               rec_valid,
    output vcsp_pkg::record_t  rec
);

    typedef enum logic [2:0] {
        PH_OPCODE   = 3'd0,
        PH_OPERANDS = 3'd1,
        PH_MARKER   = 3'd2,
        PH_BTYPE    = 3'd3,
        PH_BSIZE    = 3'd4,
        PH_PAYLOAD  = 3'd5
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [7:0]   held_opcode_reg, held_opcode_next;
    logic [2:0]   operand_count_reg, operand_count_next;
    logic [2:0]   need_reg, need_next;
    logic [31:0]  operand_accum_reg, operand_accum_next;
    logic [7:0]   held_register_reg, held_register_next;
    logic [7:0]   held_block_kind_reg, held_block_kind_next;
    logic [31:0]  payload_left_reg, payload_left_next;

    logic [2:0]   count_inc;
    logic [31:0]  accum_merged;
    logic [31:0]  left_dec;
    logic [2:0]   op_need;

    assign count_inc    = operand_count_reg + 3'd1;
    assign accum_merged = operand_accum_reg
                        | (32'(stream_byte) << {operand_count_reg[1:0], 3'b000});
    assign left_dec     = payload_left_reg - 32'd1;
    assign op_need      = vcsp_pkg::operands_needed(stream_byte);

    always_comb
    begin
        phase_next           = phase_reg;
        held_opcode_next     = held_opcode_reg;
        operand_count_next   = operand_count_reg;
        need_next            = need_reg;
        operand_accum_next   = operand_accum_reg;
        held_register_next   = held_register_reg;
        held_block_kind_next = held_block_kind_reg;
        payload_left_next    = payload_left_reg;
        rec                  = '0;
        rec_valid            = 1'b0;

        if (take)
        begin
            unique case (phase_reg)
                PH_OPCODE:
                begin
                    held_opcode_next   = stream_byte;
                    operand_count_next = 3'd0;
                    operand_accum_next = 32'd0;
                    rec.opcode         = stream_byte;
                    priority if (stream_byte == vcsp_pkg::OP_END)
                    begin
                        rec.record_kind = vcsp_pkg::KIND_END;
                        rec_valid       = 1'b1;
                    end
                    else if (stream_byte == vcsp_pkg::OP_WAIT_NTSC)
                    begin
                        rec.record_kind  = vcsp_pkg::KIND_WAIT;
                        rec.wait_samples = vcsp_pkg::WAIT_NTSC_SAMPLES;
                        rec_valid        = 1'b1;
                    end
                    else if (stream_byte == vcsp_pkg::OP_WAIT_PAL)
                    begin
                        rec.record_kind  = vcsp_pkg::KIND_WAIT;
                        rec.wait_samples = vcsp_pkg::WAIT_PAL_SAMPLES;
                        rec_valid        = 1'b1;
                    end
                    else if (stream_byte[7:4] == vcsp_pkg::OP_SHORT_WAIT)
                    begin
                        rec.record_kind  = vcsp_pkg::KIND_WAIT;
                        rec.wait_samples = 16'(stream_byte[3:0]) + 16'd1;
                        rec_valid        = 1'b1;
                    end
                    else if (stream_byte == vcsp_pkg::OP_BLOCK)
                    begin
                        phase_next = PH_MARKER;
                    end
                    else if (op_need != 3'd0)
                    begin
                        phase_next = PH_OPERANDS;
                        need_next  = op_need;
                    end
                    else
                    begin
                        rec.record_kind = vcsp_pkg::KIND_UNKNOWN;
                        rec_valid       = 1'b1;
                    end
                end

                PH_OPERANDS:
                begin
                    if (held_opcode_reg != vcsp_pkg::OP_WRITE_DATA && operand_count_reg == 3'd0)
                        held_register_next = stream_byte;
                    operand_accum_next = accum_merged;
                    operand_count_next = count_inc;
                    if (count_inc == need_reg)
                    begin
                        phase_next = PH_OPCODE;
                        rec_valid  = 1'b1;
                        rec.opcode = held_opcode_reg;
                        priority if (held_opcode_reg == vcsp_pkg::OP_WAIT)
                        begin
                            rec.record_kind  = vcsp_pkg::KIND_WAIT;
                            rec.wait_samples = accum_merged[15:0];
                        end
                        else if (held_opcode_reg == vcsp_pkg::OP_SEEK)
                        begin
                            rec.record_kind   = vcsp_pkg::KIND_PCM_SEEK;
                            rec.sample_offset = accum_merged;
                        end
                        else if (held_opcode_reg == vcsp_pkg::OP_WRITE_DATA)
                        begin
                            rec.record_kind = vcsp_pkg::KIND_REG_WRITE;
                            rec.chip_value  = accum_merged[7:0];
                        end
                        else
                        begin
                            rec.record_kind   = vcsp_pkg::KIND_REG_WRITE;
                            rec.chip_register = held_register_reg;
                            rec.chip_value    = accum_merged[15:8];
                            rec.chip_port     = (held_opcode_reg == vcsp_pkg::OP_PORT1_A)
                                             || (held_opcode_reg == vcsp_pkg::OP_PORT1_B)
                                             || (held_opcode_reg == vcsp_pkg::OP_PORT1_C);
                        end
                    end
                end

                PH_MARKER:
                begin
                    if (stream_byte == vcsp_pkg::BLOCK_MARKER)
                    begin
                        phase_next = PH_BTYPE;
                    end
                    else
                    begin
                        phase_next      = PH_OPCODE;
                        rec.record_kind = vcsp_pkg::KIND_NO_MARKER;
                        rec.opcode      = vcsp_pkg::OP_BLOCK;
                        rec_valid       = 1'b1;
                    end
                end

                PH_BTYPE:
                begin
                    held_block_kind_next = stream_byte;
                    operand_count_next   = 3'd0;
                    operand_accum_next   = 32'd0;
                    phase_next           = PH_BSIZE;
                end

                PH_BSIZE:
                begin
                    operand_accum_next = accum_merged;
                    operand_count_next = count_inc;
                    if (operand_count_reg == 3'd3)
                    begin
                        payload_left_next = accum_merged;
                        phase_next        = (accum_merged != 32'd0) ? PH_PAYLOAD : PH_OPCODE;
                        rec.record_kind   = vcsp_pkg::KIND_BLOCK_HDR;
                        rec.opcode        = vcsp_pkg::OP_BLOCK;
                        rec.block_kind    = held_block_kind_reg;
                        rec.block_length  = accum_merged;
                        rec_valid         = 1'b1;
                    end
                end

                PH_PAYLOAD:
                begin
                    payload_left_next = left_dec;
                    rec.record_kind   = vcsp_pkg::KIND_BLOCK_BYTE;
                    rec.opcode        = vcsp_pkg::OP_BLOCK;
                    rec.block_kind    = held_block_kind_reg;
                    rec.payload_byte  = stream_byte;
                    rec_valid         = 1'b1;
                    if (left_dec == 32'd0)
                    begin
                        rec.payload_last = 1'b1;
                        phase_next       = PH_OPCODE;
                    end
                end

                default:
                begin
                    phase_next = PH_OPCODE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_OPCODE;
            held_opcode_reg     <= 8'd0;
            operand_count_reg   <= 3'd0;
            need_reg            <= 3'd0;
            operand_accum_reg   <= 32'd0;
            held_register_reg   <= 8'd0;
            held_block_kind_reg <= 8'd0;
            payload_left_reg    <= 32'd0;
        end
        else
        begin
            phase_reg           <= phase_next;
            held_opcode_reg     <= held_opcode_next;
            operand_count_reg   <= operand_count_next;
            need_reg            <= need_next;
            operand_accum_reg   <= operand_accum_next;
            held_register_reg   <= held_register_next;
            held_block_kind_reg <= held_block_kind_next;
            payload_left_reg    <= payload_left_next;
        end
    end

    // A payload phase always has at least one byte still to come.
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> payload_left_reg != 32'd0)
        else $error("payload phase with no bytes left");

    // While collecting operands the count stays below the operand need.
    a_operands_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_OPERANDS |-> (operand_count_reg < need_reg && need_reg <= 3'd4))
        else $error("operand count out of range");

    // A bad block marker returns the parser to opcode decoding.
    a_marker_recover: assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == PH_MARKER && stream_byte != vcsp_pkg::BLOCK_MARKER)
        |=> phase_reg == PH_OPCODE)
        else $error("parser did not resume after a missing marker");

endmodule

/* rtl/core/vcsp_out_queue.sv */
// ============================================================================
// VGM command stream parser output queue
// Two-entry record queue that keeps the input side running while the
// receiver stalls.
// ============================================================================
module vcsp_out_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vcsp_pkg::record_t  push_rec,
    output logic               has_space,
    output logic               out_valid,
    input  logic               out_ready,
    output vcsp_pkg::record_t  out_rec
);

    vcsp_pkg::record_t  slot_mem [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               pop;

    assign has_space = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_rec   = slot_mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_mem[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The queue never overfills.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> has_space)
        else $error("record pushed into a full queue");

    // Occupancy agrees with the pointer distance.
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with occupancy");

endmodule

/* rtl/core/vgm_command_stream_parser.sv */
// ============================================================================
// VGM command stream parser
// Parses a VGM command stream into records, one word per cycle with queue space.
// ============================================================================
// The input channel (stream_byte, byte_valid, byte_ready) carries one byte of
// the command stream per word. The output channel (record_valid,
// record_ready and the record fields) carries one parsed record per word.
//
// A record appears on the byte that completes a command and on every payload
// byte of a data block. Earlier operand bytes, a matching block marker, the
// block type and the first three length bytes produce no record. Fields that
// do not belong to a record's kind read as zero.
//
// A record is queued as the byte completing it is taken and shows once older
// records have left. Throughput is one byte per cycle while the queue has room,
// set by the single parse step between the parse state registers and the queue.
//
// Reset puts the parser in opcode decoding with all held values cleared and
// empties the output queue. When the receiver stalls, a two-entry queue holds
// records; byte_ready drops only while both entries are full, so the stream
// keeps moving through short stalls at full rate.
// ============================================================================
module vgm_command_stream_parser
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   stream_byte,
    input  logic         byte_valid,
    output logic         byte_ready,
    output logic         record_valid,
    input  logic         record_ready,
    output logic [2:0]   record_kind,
    output logic [7:0]   opcode,
    output logic [15:0]  wait_samples,
    output logic [7:0]   chip_register,
    output logic [7:0]   chip_value,
    output logic         chip_port,
    output logic [7:0]   block_kind,
    output logic [31:0]  block_length,
    output logic [31:0]  sample_offset,
    output logic [7:0]   payload_byte,
    output logic         payload_last
);

    logic               take;
    logic               rec_valid;
    logic               has_space;
    vcsp_pkg::record_t  rec;
    vcsp_pkg::record_t  out_rec;

    // A byte is taken whenever the queue has room for the record it may make.
    assign byte_ready = has_space;
    assign take       = byte_valid && has_space;

    vcsp_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .stream_byte (stream_byte),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    vcsp_out_queue u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_valid),
        .push_rec  (rec),
        .has_space (has_space),
        .out_valid (record_valid),
        .out_ready (record_ready),
        .out_rec   (out_rec)
    );

    // Unpack the queued record onto the output ports.
    assign record_kind   = out_rec.record_kind;
    assign opcode        = out_rec.opcode;
    assign wait_samples  = out_rec.wait_samples;
    assign chip_register = out_rec.chip_register;
    assign chip_value    = out_rec.chip_value;
    assign chip_port     = out_rec.chip_port;
    assign block_kind    = out_rec.block_kind;
    assign block_length  = out_rec.block_length;
    assign sample_offset = out_rec.sample_offset;
    assign payload_byte  = out_rec.payload_byte;
    assign payload_last  = out_rec.payload_last;

endmodule
